@@ rtl/ami_pkg.sv @@
// Shared constants and types for the affine matrix inverse block.
package ami_pkg;

  localparam int unsigned ELEMS = 12;
  localparam int unsigned IDX_W = 4;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t       LAST_IDX  = idx_t'(ELEMS - 1);
  localparam logic [1:0] TRANS_COL = 2'd3;

endpackage

@@ rtl/ami_if.sv @@
// Matrix input channel and inverse element output channel.
interface ami_in_if #(parameter int ELEM_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] m00, m01, m02, tx;
  logic signed [ELEM_WIDTH-1:0] m10, m11, m12, ty;
  logic signed [ELEM_WIDTH-1:0] m20, m21, m22, tz;

  modport source (output valid, m00, m01, m02, tx, m10, m11, m12, ty,
                  m20, m21, m22, tz, input ready);
  modport sink   (input valid, m00, m01, m02, tx, m10, m11, m12, ty,
                  m20, m21, m22, tz, output ready);
endinterface

interface ami_out_if #(parameter int ELEM_WIDTH = 32);
  import ami_pkg::*;
  logic                         valid;
  logic                         ready;
  idx_t                         elem_index;
  logic signed [ELEM_WIDTH-1:0] elem_value;
  logic                         singular;
  logic                         last;

  modport source (output valid, elem_index, elem_value, singular, last, input ready);
  modport sink   (input valid, elem_index, elem_value, singular, last, output ready);
endinterface

@@ rtl/affine_matrix_inverse_core.sv @@
// Inverse of a 3x4 affine matrix in fixed point, pipelined.
//
// in_ch carries one matrix per beat: twelve signed Q(FRAC_BITS) elements,
// row-major, translation in the fourth column. out_ch returns the inverse
// one element per beat in row-major order with its index; last marks the
// final beat of a matrix. A matrix with zero determinant gives one beat with
// singular set, index 0 and value 0.
// An accepted matrix passes in order through five cofactor and determinant
// stages, a serializer, two operand stages, a divider entry stage,
// ELEM_WIDTH-1 restoring divider stages (one quotient bit each) and the
// output register. The divider takes one element per cycle while out_ch
// does not stall; the serializer accepts a new matrix once it emits the last
// element of the previous one (its single beat for a singular one).
// Reset clears all valid bits; payload registers keep their contents.
// When out_ch stalls, a skid register takes the beat in flight and the whole
// pipeline holds; nothing is lost or repeated.
module affine_matrix_inverse_core #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ami_in_if.sink      in_ch,
  ami_out_if.source   out_ch
);
  import ami_pkg::*;

  localparam int E    = ELEM_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * E;
  localparam int CW   = 2 * E + 1;
  localparam int PLW  = 2 * E + 1;
  localparam int TPW  = 3 * E + 2;
  localparam int SW   = 3 * E + 4;
  localparam int DW   = SW;
  localparam int LINW = CW + 2 * F;
  localparam int TRW  = SW + F;
  localparam int NW   = (LINW > TRW) ? LINW : TRW;
  localparam int QB   = E - 1;
  localparam int RW   = DW + 1;

  localparam int MA [18] = '{4, 7, 7, 1, 1, 4, 6, 3, 0, 6, 3, 0, 3, 6, 6, 0, 0, 3};
  localparam int MB [18] = '{8, 5, 2, 8, 5, 2, 5, 8, 8, 2, 2, 5, 7, 4, 1, 7, 4, 1};
  localparam int XI [12] = '{0, 1, 2, 3, 4, 5, 3, 4, 5, 3, 4, 5};
  localparam int CI [12] = '{0, 3, 6, 0, 1, 2, 3, 4, 5, 6, 7, 8};

  typedef logic signed [E-1:0]  elem_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef struct packed {
    logic [DW-1:0] dm;
    logic [DW-1:0] rem;
    logic [QB-1:0] nlo;
    logic [QB-1:0] q;
    logic          neg;
    logic          big;
    logic          sing;
    logic          last;
    idx_t          idx;
  } dst_t;

  typedef struct packed {
    idx_t          idx;
    logic [E-1:0]  val;
    logic          sing;
    logic          last;
  } beat_t;

  // front stages
  logic [5:1] fv_r;
  logic [5:1] fr;
  elem_t      mi [9];
  elem_t      op0 [6];

  logic signed [PW-1:0]  pr1_r  [18];
  elem_t                 op1_r  [6];
  cof_t                  cof2_r [9];
  elem_t                 op2_r  [6];
  logic signed [PLW-1:0] plo3_r [12];
  logic signed [PLW-1:0] phi3_r [12];
  cof_t                  cof3_r [9];
  logic signed [TPW-1:0] tp4_r  [12];
  cof_t                  cof4_r [9];
  sum_t                  det5_r;
  sum_t                  tn5_r  [3];
  cof_t                  cof5_r [9];

  // serializer
  logic   ser_v_r;
  idx_t   cnt_r;
  logic   ser_dz_r;
  sum_t   ser_det_r;
  sum_t   ser_el_r [12];
  logic   ser_done;
  logic   ser_emit;
  logic   ser_free;
  logic   ser_load;
  sum_t   el_nxt [12];

  // operand stages
  logic          adv;
  logic          e_v_r;
  sum_t          e_sel_r;
  sum_t          e_det_r;
  logic          e_lin_r;
  idx_t          e_idx_r;
  logic          e_sing_r;
  logic          e_last_r;
  logic [SW-1:0] sel_abs;
  logic [SW-1:0] det_abs;

  logic          a_v_r;
  logic [NW-1:0] a_nm_r;
  logic [DW-1:0] a_dm_r;
  logic          a_neg_r;
  idx_t          a_idx_r;
  logic          a_sing_r;
  logic          a_last_r;

  // divider
  logic [QB:0] dv_r;
  dst_t        d_r   [QB+1];
  dst_t        d_nxt [QB+1];

  // output
  logic  o_v_r;
  beat_t o_r;
  logic  k_v_r;
  beat_t k_r;
  beat_t fin;
  logic  incoming;

  always_comb begin
    mi[0] = in_ch.m00; mi[1] = in_ch.m01; mi[2] = in_ch.m02;
    mi[3] = in_ch.m10; mi[4] = in_ch.m11; mi[5] = in_ch.m12;
    mi[6] = in_ch.m20; mi[7] = in_ch.m21; mi[8] = in_ch.m22;
    op0[0] = in_ch.m00; op0[1] = in_ch.m01; op0[2] = in_ch.m02;
    op0[3] = in_ch.tx;  op0[4] = in_ch.ty;  op0[5] = in_ch.tz;
  end

  assign adv      = !k_v_r;
  assign ser_done = ser_dz_r || (cnt_r == LAST_IDX);
  assign ser_emit = adv && ser_v_r;
  assign ser_free = !ser_v_r || (ser_emit && ser_done);
  assign ser_load = fv_r[5] && ser_free;

  assign fr[5] = !fv_r[5] || ser_free;
  assign fr[4] = !fv_r[4] || fr[5];
  assign fr[3] = !fv_r[3] || fr[4];
  assign fr[2] = !fv_r[2] || fr[3];
  assign fr[1] = !fv_r[1] || fr[2];
  assign in_ch.ready = fr[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      if (fr[1]) fv_r[1] <= in_ch.valid;
      if (fr[2]) fv_r[2] <= fv_r[1];
      if (fr[3]) fv_r[3] <= fv_r[2];
      if (fr[4]) fv_r[4] <= fv_r[3];
      if (fr[5]) fv_r[5] <= fv_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (fr[1]) begin
      for (int k = 0; k < 18; k++) pr1_r[k] <= mi[MA[k]] * mi[MB[k]];
      op1_r <= op0;
    end
    if (fr[2]) begin
      for (int k = 0; k < 9; k++) cof2_r[k] <= CW'(pr1_r[2*k]) - CW'(pr1_r[2*k+1]);
      op2_r <= op1_r;
    end
    if (fr[3]) begin
      for (int j = 0; j < 12; j++) begin
        plo3_r[j] <= op2_r[XI[j]] * $signed({1'b0, cof2_r[CI[j]][E-1:0]});
        phi3_r[j] <= op2_r[XI[j]] * $signed(cof2_r[CI[j]][CW-1:E]);
      end
      cof3_r <= cof2_r;
    end
    if (fr[4]) begin
      for (int j = 0; j < 12; j++) tp4_r[j] <= (TPW'(phi3_r[j]) <<< E) + TPW'(plo3_r[j]);
      cof4_r <= cof3_r;
    end
    if (fr[5]) begin
      det5_r <= SW'(tp4_r[0]) + SW'(tp4_r[1]) + SW'(tp4_r[2]);
      for (int r = 0; r < 3; r++)
        tn5_r[r] <= -(SW'(tp4_r[3+3*r]) + SW'(tp4_r[4+3*r]) + SW'(tp4_r[5+3*r]));
      cof5_r <= cof4_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        if (k < 3) el_nxt[r*4+k] = SW'(cof5_r[r*3+k]);
        else       el_nxt[r*4+k] = tn5_r[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r   <= '0;
    end else if (ser_load) begin
      ser_v_r <= 1'b1;
      cnt_r   <= '0;
    end else if (ser_emit) begin
      if (ser_done) ser_v_r <= 1'b0;
      cnt_r <= cnt_r + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_det_r <= det5_r;
      ser_dz_r  <= (det5_r == '0);
      ser_el_r  <= el_nxt;
    end
  end

  assign sel_abs = e_sel_r[SW-1] ? unsigned'(-e_sel_r) : unsigned'(e_sel_r);
  assign det_abs = e_det_r[SW-1] ? unsigned'(-e_det_r) : unsigned'(e_det_r);

  always_comb begin
    logic [RW-1:0] t;
    logic          ge;
    t  = '0;
    ge = 1'b0;
    d_nxt[0].dm   = a_dm_r;
    d_nxt[0].rem  = DW'(a_nm_r[NW-1:QB]);
    d_nxt[0].nlo  = a_nm_r[QB-1:0];
    d_nxt[0].q    = '0;
    d_nxt[0].neg  = a_neg_r;
    d_nxt[0].big  = (a_nm_r[NW-1:QB] >= a_dm_r);
    d_nxt[0].sing = a_sing_r;
    d_nxt[0].last = a_last_r;
    d_nxt[0].idx  = a_idx_r;
    for (int k = 1; k <= QB; k++) begin
      t  = {d_r[k-1].rem, d_r[k-1].nlo[QB-k]};
      ge = (t >= {1'b0, d_r[k-1].dm});
      d_nxt[k]     = d_r[k-1];
      d_nxt[k].rem = ge ? DW'(t - {1'b0, d_r[k-1].dm}) : DW'(t);
      d_nxt[k].q   = {d_r[k-1].q[QB-2:0], ge};
    end
  end

  always_comb begin
    fin.idx  = d_r[QB].idx;
    fin.sing = d_r[QB].sing;
    fin.last = d_r[QB].last;
    if (d_r[QB].sing)
      fin.val = '0;
    else if (d_r[QB].big)
      fin.val = d_r[QB].neg ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    else
      fin.val = d_r[QB].neg ? -{1'b0, d_r[QB].q} : {1'b0, d_r[QB].q};
  end

  assign incoming = adv && dv_r[QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      a_v_r <= 1'b0;
      dv_r  <= '0;
    end else if (adv) begin
      e_v_r <= ser_v_r;
      a_v_r <= e_v_r;
      dv_r  <= {dv_r[QB-1:0], a_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_sel_r  <= ser_el_r[cnt_r];
      e_det_r  <= ser_det_r;
      e_lin_r  <= (cnt_r[1:0] != TRANS_COL);
      e_idx_r  <= cnt_r;
      e_sing_r <= ser_dz_r;
      e_last_r <= ser_done;
      a_nm_r   <= e_lin_r ? (NW'(sel_abs) << (2 * F)) : (NW'(sel_abs) << F);
      a_dm_r   <= det_abs;
      a_neg_r  <= e_sel_r[SW-1] ^ e_det_r[SW-1];
      a_idx_r  <= e_idx_r;
      a_sing_r <= e_sing_r;
      a_last_r <= e_last_r;
      d_r      <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      k_v_r <= 1'b0;
    end else if (o_v_r && !out_ch.ready) begin
      if (incoming) k_v_r <= 1'b1;
    end else if (k_v_r) begin
      o_v_r <= 1'b1;
      k_v_r <= 1'b0;
    end else begin
      o_v_r <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (o_v_r && !out_ch.ready) begin
      if (incoming) k_r <= fin;
    end else if (k_v_r) begin
      o_r <= k_r;
    end else if (incoming) begin
      o_r <= fin;
    end
  end

  assign out_ch.valid      = o_v_r;
  assign out_ch.elem_index = o_r.idx;
  assign out_ch.elem_value = o_r.val;
  assign out_ch.singular   = o_r.sing;
  assign out_ch.last       = o_r.last;

endmodule

@@ test/tb.sv @@
// Testbench for affine_matrix_inverse_core: directed and random matrices against an exact model.
module tb;
  import ami_pkg::*;

  localparam int  EW         = 32;
  localparam int  FB         = 16;
  localparam int  LIMIT      = 400000;
  localparam int  DRAIN      = 100;
  localparam int  RAND_ITEMS = 96;

  typedef logic signed [EW-1:0]  elem_t;
  typedef elem_t                 mat_t [ELEMS];
  typedef logic signed [191:0]   wide_t;

  typedef struct packed {
    idx_t  index;
    elem_t value;
    logic  singular;
    logic  last;
  } beat_t;

  class inverse_scoreboard;
    beat_t inverse_q[$];
    int    mismatches;

    function elem_t clamp(input wide_t q);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (EW - 1)) - 1;
      lo = -(wide_t'(1) <<< (EW - 1));
      if (q > hi) return elem_t'(hi);
      if (q < lo) return elem_t'(lo);
      return elem_t'(q);
    endfunction

    function void note_matrix(input mat_t m);
      wide_t e [ELEMS];
      wide_t cof [3][3];
      wide_t det, num;
      beat_t b;
      int    r, c;
      for (int k = 0; k < ELEMS; k++) e[k] = m[k];
      det = e[0]*e[5]*e[10] + e[1]*e[6]*e[8] + e[2]*e[4]*e[9]
          - e[0]*e[6]*e[9] - e[1]*e[4]*e[10] - e[2]*e[5]*e[8];
      if (det == 0) begin
        b = '{index: '0, value: '0, singular: 1'b1, last: 1'b1};
        inverse_q.push_back(b);
        return;
      end
      cof[0][0] = e[5]*e[10] - e[9]*e[6];
      cof[0][1] = e[9]*e[2]  - e[1]*e[10];
      cof[0][2] = e[1]*e[6]  - e[5]*e[2];
      cof[1][0] = e[8]*e[6]  - e[4]*e[10];
      cof[1][1] = e[0]*e[10] - e[8]*e[2];
      cof[1][2] = e[4]*e[2]  - e[0]*e[6];
      cof[2][0] = e[4]*e[9]  - e[8]*e[5];
      cof[2][1] = e[8]*e[1]  - e[0]*e[9];
      cof[2][2] = e[0]*e[5]  - e[4]*e[1];
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 4; c++) begin
          if (c != TRANS_COL) num = cof[r][c] <<< (2 * FB);
          else num = -(cof[r][0]*e[3] + cof[r][1]*e[7] + cof[r][2]*e[11]) <<< FB;
          b.index    = idx_t'(r * 4 + c);
          b.value    = clamp(num / det);
          b.singular = 1'b0;
          b.last     = (b.index == LAST_IDX);
          inverse_q.push_back(b);
        end
      end
    endfunction

    function void check_beat(input beat_t got);
      beat_t exp_b;
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: idx %0d value %0d singular %0b last %0b",
                   got.index, got.value, got.singular, got.last);
        return;
      end
      exp_b = inverse_q.pop_front();
      if (got !== exp_b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp idx %0d val %0d s %0b l %0b, got idx %0d val %0d s %0b l %0b",
                   exp_b.index, exp_b.value, exp_b.singular, exp_b.last,
                   got.index, got.value, got.singular, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  inverse_scoreboard sb = new();

  ami_in_if  #(.ELEM_WIDTH(EW)) in_ch ();
  ami_out_if #(.ELEM_WIDTH(EW)) out_ch ();

  affine_matrix_inverse_core #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid  = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.tx} = '0;
    {in_ch.m10, in_ch.m11, in_ch.m12, in_ch.ty} = '0;
    {in_ch.m20, in_ch.m21, in_ch.m22, in_ch.tz} = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_beat('{index: out_ch.elem_index, value: out_ch.elem_value,
                      singular: out_ch.singular, last: out_ch.last});
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_matrix(input mat_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.m00 <= m[0]; in_ch.m01 <= m[1]; in_ch.m02 <= m[2];  in_ch.tx <= m[3];
    in_ch.m10 <= m[4]; in_ch.m11 <= m[5]; in_ch.m12 <= m[6];  in_ch.ty <= m[7];
    in_ch.m20 <= m[8]; in_ch.m21 <= m[9]; in_ch.m22 <= m[10]; in_ch.tz <= m[11];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_matrix(m);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.inverse_q.size() != 0) @(posedge clk);
  endtask

  function automatic elem_t rand_elem(input int mode);
    case (mode)
      0:       return elem_t'($urandom_range(0, 2**19)) - elem_t'(2**18);
      1:       return elem_t'($urandom);
      default: return elem_t'($urandom_range(0, 64)) - elem_t'(32);
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t m;
    int   mode, pick;
    pick = $urandom_range(99);
    mode = (pick < 60) ? 0 : (pick < 80) ? 1 : 2;
    for (int k = 0; k < ELEMS; k++) m[k] = rand_elem(mode);
    // duplicate a linear row now and then to force a zero determinant
    if ($urandom_range(99) < 12) begin
      m[4] = m[0]; m[5] = m[1]; m[6] = m[2];
    end
    return m;
  endfunction

  task automatic directed_run();
    mat_t  m;
    elem_t one, mx, mn;
    one = elem_t'(1 << FB);
    mx  = {1'b0, {(EW-1){1'b1}}};
    mn  = {1'b1, {(EW-1){1'b0}}};
    m = '{one, 0, 0, 0, 0, one, 0, 0, 0, 0, one, 0};
    send_matrix(m);
    m = '{one, 0, 0, mx, 0, one, 0, mn, 0, 0, one, -1};
    send_matrix(m);
    m = '{default: 0};
    send_matrix(m);
    m = '{default: mx};
    send_matrix(m);
    m = '{default: mn};
    send_matrix(m);
    m = '{mx, 0, 0, mx, 0, mx, 0, mn, 0, 0, mx, mx};
    send_matrix(m);
    m = '{mn, 0, 0, mn, 0, mn, 0, mx, 0, 0, mn, mn};
    send_matrix(m);
    m = '{1, 0, 0, mx, 0, 1, 0, mn, 0, 0, 1, one};
    send_matrix(m);
    m = '{-1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0};
    send_matrix(m);
    m = '{mx, mn, mx, -1, mn, mx, mn, 1, mx, mx, mn, 0};
    send_matrix(m);
    m = '{0, one, 0, one, one, 0, 0, -one, 0, 0, 2*one, 3*one};
    send_matrix(m);
    m = '{one, 2*one, 3*one, 0, 2*one, 4*one, 6*one, 0, 1, 1, 1, 1};
    send_matrix(m);
  endtask

  initial begin
    int idle_set [4];
    int stall_set [4];
    idle_set  = '{0, 53, 0, 16};
    stall_set = '{0, 0, 53, 16};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_run();
    wait_drained();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_set[p];
      recv_stall_pct = stall_set[p];
      for (int i = 0; i < RAND_ITEMS / 4 + 1; i++) send_matrix(rand_matrix());
      wait_drained();
    end
    recv_stall_pct = 0;
    repeat (DRAIN) @(posedge clk);
    if (sb.mismatches == 0 && sb.inverse_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
